// ===== src/assert_macros.svh =====
// assertion macros for the ticket table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ATT_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ATT_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ATT_ASSERT_IMPL(label, clk, rst, prop, msg)
`define ATT_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== src/att_pkg.sv =====
// ----------------------------------------------------------------------------
// att_pkg
// shared types and constants of the aging ticket table
// ----------------------------------------------------------------------------
package att_pkg;
   localparam int TableEntries = 16;
   localparam int SweepMax     = 16;

   typedef enum logic [2:0] {
      ACT_INSERT  = 3'd0,
      ACT_REFRESH = 3'd1,
      ACT_EXPIRE  = 3'd2,
      ACT_CHECK   = 3'd3,
      ACT_SWEEP   = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_DUP      = 3'd1,
      ST_NOTFOUND = 3'd2,
      ST_OWNER    = 3'd3,
      ST_IP       = 3'd4,
      ST_FULL     = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_READ,
      S_WRITE,
      S_EMIT,
      S_SWEEP_SCAN,
      S_SWEEP_EMIT
   } state_type;

   // comparison request into the shared scan unit
   typedef struct packed {
      logic        first;
      logic        sweep;
      logic [31:0] now;
      logic [31:0] stamp_ctr;
   } scan_ctl_type;
endpackage

// ===== src/aging_ticket_table_top.sv =====
// ----------------------------------------------------------------------------
// aging_ticket_table_top
// authentication ticket table with key lookup and deadline ordered sweep
// ----------------------------------------------------------------------------
// insert/refresh/expire/check: result registered after a full scan, S_READ, S_WRITE and S_EMIT
// sweep: one full scan per removed key, up to 16 keys
// requests: req_stall holds off a new request until the previous one is done; the scan reads one entry per cycle
// reset: synchronous, empties the table and clears the stamp counter
module aging_ticket_table_top
   import att_pkg::*;
#(
   parameter int TABLE_ENTRIES = TableEntries
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic [31:0] req_owner_id,
   input  logic [63:0] req_ticket_key,
   input  logic [31:0] req_client_ip,
   input  logic [31:0] req_now_time,
   input  logic [31:0] req_lifetime,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [63:0] rsp_swept_key,
   output logic        rsp_swept_valid,
   output logic        rsp_last
);
`include "assert_macros.svh"
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 2);
   localparam int SW_W  = $clog2(SweepMax + 1);

   // table memories, one read and one write port each, registered read
   logic [63:0] key_mem      [TABLE_ENTRIES];
   logic [31:0] owner_mem    [TABLE_ENTRIES];
   logic [31:0] ip_mem       [TABLE_ENTRIES];
   logic [31:0] interval_mem [TABLE_ENTRIES];
   logic [31:0] deadline_mem [TABLE_ENTRIES];
   logic [31:0] stamp_mem    [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] used_ff;

   state_type   state_ff, state_in;
   logic [2:0]  act_ff;
   logic [31:0] owner_ff, ip_ff, now_ff, life_ff;
   logic [63:0] key_ff;
   logic [31:0] stamp_ctr_ff;
   logic [CNT_W-1:0] cnt_ff;        // scan address pointer, plus pipe drain
   logic [SW_W-1:0]  swept_ff;
   logic        rd_en_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic        first_ff;

   // registered read data
   logic [63:0] rkey_ff;
   logic [31:0] rowner_ff, rip_ff, rint_ff, rdl_ff, rstamp_ff;
   logic        rused_ff;

   // output register
   logic        ov_ff;
   logic [2:0]  ostat_ff;
   logic [63:0] okey_ff;
   logic        oswv_ff, olast_ff;

   logic        hit, free_f, best, multi;
   logic [IDX_W-1:0] hit_idx, free_idx, best_idx;
   scan_ctl_type ctl;

   logic        accept, scan_phase, scan_done, issue;
   logic [IDX_W-1:0] issue_idx;
   logic [32:0] sum;
   logic [31:0] sat;
   logic [2:0]  auth_st;

   assign accept     = req_valid && !req_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign scan_phase = (state_ff == S_SCAN) || (state_ff == S_SWEEP_SCAN);
   // issue addresses 0..N-1, then let the read and compare registers drain
   assign issue      = scan_phase && (cnt_ff < CNT_W'(TABLE_ENTRIES));
   assign issue_idx  = cnt_ff[IDX_W-1:0];
   assign scan_done  = scan_phase && (cnt_ff == CNT_W'(TABLE_ENTRIES + 1));

   assign ctl.first     = first_ff;
   assign ctl.sweep     = (act_ff == ACT_SWEEP);
   assign ctl.now       = now_ff;
   assign ctl.stamp_ctr = stamp_ctr_ff;

   att_scan #(.IDX_W(IDX_W)) u_scan (
      .clock(clock), .reset(reset), .ctl(ctl), .valid_in(rd_en_ff),
      .idx(rd_idx_ff), .used(rused_ff), .key(key_ff), .ent_key(rkey_ff),
      .ent_deadline(rdl_ff), .ent_stamp(rstamp_ff),
      .hit_ff(hit), .hit_idx_ff(hit_idx), .free_ff(free_f),
      .free_idx_ff(free_idx), .best_ff(best), .best_idx_ff(best_idx),
      .multi_ff(multi)
   );

   // memory read port, address chosen by scan pointer, hit or sweep winner
   always_ff @(posedge clock) begin
      logic [IDX_W-1:0] a;
      a = issue ? issue_idx : (ctl.sweep ? best_idx : hit_idx);
      rkey_ff   <= key_mem[a];
      rowner_ff <= owner_mem[a];
      rip_ff    <= ip_mem[a];
      rint_ff   <= interval_mem[a];
      rdl_ff    <= deadline_mem[a];
      rstamp_ff <= stamp_mem[a];
      rused_ff  <= used_ff[a];
      rd_idx_ff <= a;
   end

   // saturating deadline from read interval or request lifetime
   assign sum = {1'b0, now_ff} +
                {1'b0, (act_ff == ACT_INSERT) ? life_ff : rint_ff};
   assign sat = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

   always_comb begin
      if (!hit)                                  auth_st = ST_NOTFOUND;
      else if (rowner_ff != owner_ff)            auth_st = ST_OWNER;
      else if (rip_ff != 32'd0 && rip_ff != ip_ff) auth_st = ST_IP;
      else                                       auth_st = ST_OK;
   end

   // memory write port
   always_ff @(posedge clock) begin
      if (state_ff == S_WRITE && act_ff == ACT_INSERT && !hit && free_f) begin
         key_mem[free_idx]      <= key_ff;
         owner_mem[free_idx]    <= owner_ff;
         ip_mem[free_idx]       <= ip_ff;
         interval_mem[free_idx] <= life_ff;
         deadline_mem[free_idx] <= sat;
         stamp_mem[free_idx]    <= stamp_ctr_ff;
      end else if (state_ff == S_WRITE && act_ff == ACT_REFRESH && auth_st == ST_OK) begin
         deadline_mem[hit_idx] <= sat;
         stamp_mem[hit_idx]    <= stamp_ctr_ff;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:       if (accept) state_in = (req_action == ACT_SWEEP) ?
                                              S_SWEEP_SCAN : S_SCAN;
         S_SCAN:       if (scan_done) state_in = S_READ;
         S_READ:       state_in = S_WRITE;
         S_WRITE:      state_in = S_EMIT;
         S_EMIT:       if (!ov_ff || !rsp_stall) state_in = S_IDLE;
         S_SWEEP_SCAN: if (scan_done) state_in = S_SWEEP_EMIT;
         S_SWEEP_EMIT: if (!ov_ff || !rsp_stall)
                          state_in = (best && multi &&
                                      swept_ff < SW_W'(SweepMax - 1)) ?
                                     S_SWEEP_SCAN : S_IDLE;
         default:      state_in = S_IDLE;
      endcase
   end

   // control and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         stamp_ctr_ff <= '0;
         ov_ff        <= 1'b0;
         rd_en_ff     <= 1'b0;
         cnt_ff       <= '0;
         first_ff     <= 1'b0;
         swept_ff     <= '0;
      end else begin
         state_ff <= state_ff == state_in ? state_ff : state_in;
         rd_en_ff <= issue;
         if (ov_ff && !rsp_stall) ov_ff <= 1'b0;
         if (rd_en_ff) first_ff <= 1'b0;
         if (issue || scan_phase) cnt_ff <= cnt_ff + CNT_W'(1);
         if (accept) begin
            act_ff   <= (req_action > 3'd4) ? 3'd7 : req_action;
            owner_ff <= req_owner_id;
            key_ff   <= req_ticket_key;
            ip_ff    <= req_client_ip;
            now_ff   <= req_now_time;
            life_ff  <= req_lifetime;
            cnt_ff   <= '0;
            first_ff <= 1'b1;
            swept_ff <= '0;
         end
         if (state_ff == S_WRITE) begin
            if (act_ff == ACT_INSERT && !hit && free_f) begin
               used_ff[free_idx] <= 1'b1;
               stamp_ctr_ff      <= stamp_ctr_ff + 32'd1;
            end else if (act_ff == ACT_REFRESH && auth_st == ST_OK) begin
               stamp_ctr_ff <= stamp_ctr_ff + 32'd1;
            end else if (act_ff == ACT_EXPIRE && auth_st == ST_OK) begin
               used_ff[hit_idx] <= 1'b0;
            end
         end
         // result loads only once the previous one has left
         if (state_ff == S_EMIT && (!ov_ff || !rsp_stall)) begin
            ov_ff    <= 1'b1;
            okey_ff  <= '0;
            oswv_ff  <= 1'b0;
            olast_ff <= 1'b1;
            case (act_ff)
               ACT_INSERT:  ostat_ff <= hit ? ST_DUP : (free_f ? ST_OK : ST_FULL);
               ACT_REFRESH, ACT_EXPIRE, ACT_CHECK: ostat_ff <= auth_st;
               default:     ostat_ff <= ST_OK;
            endcase
         end
         if (state_ff == S_SWEEP_EMIT && (!ov_ff || !rsp_stall)) begin
            ov_ff    <= 1'b1;
            ostat_ff <= ST_OK;
            if (best) begin
               used_ff[best_idx] <= 1'b0;
               okey_ff  <= rkey_ff;
               oswv_ff  <= 1'b1;
               olast_ff <= !(multi && swept_ff < SW_W'(SweepMax - 1));
               swept_ff <= swept_ff + SW_W'(1);
            end else begin
               // nothing stale at all, single end marker
               okey_ff  <= '0;
               oswv_ff  <= 1'b0;
               olast_ff <= 1'b1;
            end
            cnt_ff   <= '0;
            first_ff <= 1'b1;
         end
      end
   end

   assign rsp_valid       = ov_ff;
   assign rsp_status      = ostat_ff;
   assign rsp_swept_key   = okey_ff;
   assign rsp_swept_valid = oswv_ff;
   assign rsp_last        = olast_ff;

   `ATT_ASSERT_IMPL(a_busy_stall, clock, reset, (state_ff != S_IDLE) |-> req_stall, "busy but not stalled")
   `ATT_ASSERT_IMPL(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall) |=> rsp_valid, "result dropped")
   `ATT_ASSERT_IMPL(a_accept_idle, clock, reset, accept |-> (state_ff == S_IDLE), "accept while busy")
endmodule

// ===== src/att_scan.sv =====
// ----------------------------------------------------------------------------
// att_scan
// shared per-entry compare unit: key match, free slot and sweep minimum
// ----------------------------------------------------------------------------
module att_scan
   import att_pkg::*;
#(
   parameter int IDX_W = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  scan_ctl_type      ctl,
   input  logic              valid_in,
   input  logic [IDX_W-1:0]  idx,
   input  logic              used,
   input  logic [63:0]       key,
   input  logic [63:0]       ent_key,
   input  logic [31:0]       ent_deadline,
   input  logic [31:0]       ent_stamp,
   output logic              hit_ff,
   output logic [IDX_W-1:0]  hit_idx_ff,
   output logic              free_ff,
   output logic [IDX_W-1:0]  free_idx_ff,
   output logic              best_ff,
   output logic [IDX_W-1:0]  best_idx_ff,
   output logic              multi_ff
);
   logic [31:0] best_dl_ff, best_age_ff;
   logic [31:0] age;
   logic        stale, better;
   logic        hit_q, free_q, best_q, multi_q;

   assign hit_q   = ctl.first ? 1'b0 : hit_ff;
   assign free_q  = ctl.first ? 1'b0 : free_ff;
   assign best_q  = ctl.first ? 1'b0 : best_ff;
   assign multi_q = ctl.first ? 1'b0 : multi_ff;
   assign age     = ctl.stamp_ctr - ent_stamp;
   assign stale   = used && (ent_deadline < ctl.now);
   // ascending index, so strict compare keeps the lower index on full ties
   assign better = !best_q || (ent_deadline < best_dl_ff) ||
                   ((ent_deadline == best_dl_ff) && (age > best_age_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff   <= 1'b0;
         free_ff  <= 1'b0;
         best_ff  <= 1'b0;
         multi_ff <= 1'b0;
      end else if (valid_in) begin
         if (!ctl.sweep) begin
            if (!hit_q && used && ent_key == key) begin
               hit_ff     <= 1'b1;
               hit_idx_ff <= idx;
            end else begin
               hit_ff <= hit_q;
            end
            if (!free_q && !used) begin
               free_ff     <= 1'b1;
               free_idx_ff <= idx;
            end else begin
               free_ff <= free_q;
            end
            best_ff  <= 1'b0;
            multi_ff <= 1'b0;
         end else begin
            hit_ff  <= 1'b0;
            free_ff <= 1'b0;
            if (stale && better) begin
               best_ff     <= 1'b1;
               best_idx_ff <= idx;
               best_dl_ff  <= ent_deadline;
               best_age_ff <= age;
            end else begin
               best_ff <= best_q;
            end
            // a second stale entry means another sweep result follows, up to the SweepMax limit
            multi_ff <= multi_q || (stale && best_q);
         end
      end
   end
endmodule

// ===== verif/aging_ticket_table_top_test.sv =====
// ----------------------------------------------------------------------------
// aging_ticket_table_top_test
// self-checking bench: table predictor, directed cases, random ticket traffic
// ----------------------------------------------------------------------------
module aging_ticket_table_top_test
   import att_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Depth     = 16;
   localparam int IdleLimit = 20000;

   // one expected response
   typedef struct {
      logic [2:0]  status;
      logic [63:0] swept_key;
      logic        swept_valid;
      logic        last;
   } ticket_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_action = '0;
   logic [31:0] req_owner_id = '0;
   logic [63:0] req_ticket_key = '0;
   logic [31:0] req_client_ip = '0;
   logic [31:0] req_now_time = '0;
   logic [31:0] req_lifetime = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [63:0] rsp_swept_key;
   logic        rsp_swept_valid;
   logic        rsp_last;

   aging_ticket_table_top dut (.*);

   always #4 clock = ~clock;

   // predictor copy of the table
   bit          tbl_used[Depth];
   logic [63:0] tbl_key[Depth];
   logic [31:0] tbl_owner[Depth];
   logic [31:0] tbl_ip[Depth];
   logic [31:0] tbl_interval[Depth];
   logic [31:0] tbl_deadline[Depth];
   logic [31:0] tbl_stamp[Depth];
   logic [31:0] stamp_ctr;

   ticket_rsp_type pending_rsps[$];
   int  error_count = 0;
   int  idle_cycles = 0;
   bit  rsp_idle_on = 1'b1;
   bit  req_idle_on = 1'b1;

   // known keys so that most requests reuse keys from earlier inserts
   logic [63:0] key_pool[$];
   logic [31:0] owner_pool[$];
   logic [31:0] ip_pool[$];
   logic [31:0] clock_now = 32'd1000;

   function automatic logic [31:0] add_saturated(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hffff_ffff : s[31:0];
   endfunction

   function automatic int find_ticket(logic [63:0] key);
      for (int i = 0; i < Depth; i++)
         if (tbl_used[i] && tbl_key[i] == key) return i;
      return -1;
   endfunction

   function automatic bit leaves_first(int a, int b);
      logic [31:0] age_a, age_b;
      if (tbl_deadline[a] != tbl_deadline[b]) return tbl_deadline[a] < tbl_deadline[b];
      age_a = stamp_ctr - tbl_stamp[a];
      age_b = stamp_ctr - tbl_stamp[b];
      if (age_a != age_b) return age_a > age_b;
      return a < b;
   endfunction

   function automatic void push_rsp(logic [2:0] st, logic [63:0] k, bit v, bit l);
      ticket_rsp_type r;
      r.status = st; r.swept_key = k; r.swept_valid = v; r.last = l;
      pending_rsps.insert(pending_rsps.size(), r);
   endfunction

   // update the table and queue the responses of one request
   function automatic void predict_ticket_op(logic [2:0] act, logic [31:0] owner,
         logic [63:0] key, logic [31:0] ip, logic [31:0] now, logic [31:0] life);
      status_type st;
      int slot, best, n;
      st = ST_OK;
      if (act == ACT_INSERT) begin
         slot = -1;
         if (find_ticket(key) >= 0) st = ST_DUP;
         else begin
            for (int i = Depth - 1; i >= 0; i--) if (!tbl_used[i]) slot = i;
            if (slot < 0) st = ST_FULL;
            else begin
               tbl_used[slot] = 1'b1;     tbl_key[slot] = key;
               tbl_owner[slot] = owner;   tbl_ip[slot] = ip;
               tbl_interval[slot] = life;
               tbl_deadline[slot] = add_saturated(now, life);
               tbl_stamp[slot] = stamp_ctr;
               stamp_ctr++;
            end
         end
      end else if (act inside {ACT_REFRESH, ACT_EXPIRE, ACT_CHECK}) begin
         slot = find_ticket(key);
         if (slot < 0) st = ST_NOTFOUND;
         else if (tbl_owner[slot] != owner) st = ST_OWNER;
         else if (tbl_ip[slot] != 0 && tbl_ip[slot] != ip) st = ST_IP;
         else if (act == ACT_REFRESH) begin
            tbl_deadline[slot] = add_saturated(now, tbl_interval[slot]);
            tbl_stamp[slot] = stamp_ctr;
            stamp_ctr++;
         end else if (act == ACT_EXPIRE) tbl_used[slot] = 1'b0;
      end else if (act == ACT_SWEEP) begin
         n = 0;
         best = 0;
         while (n < SweepMax && best >= 0) begin
            best = -1;
            for (int i = 0; i < Depth; i++)
               if (tbl_used[i] && tbl_deadline[i] < now)
                  if (best < 0 || leaves_first(i, best)) best = i;
            if (best >= 0) begin
               tbl_used[best] = 1'b0;
               push_rsp(ST_OK, tbl_key[best], 1'b1, 1'b0);
               n++;
            end
         end
         if (n > 0) begin
            pending_rsps[$].last = 1'b1;
            return;
         end
      end
      push_rsp(st, '0, 1'b0, 1'b1);
   endfunction

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsps.size() == 0) begin
            $display("%0t: unexpected response status=%0d key=%h", $realtime,
                     rsp_status, rsp_swept_key);
            error_count++;
         end else begin
            ticket_rsp_type e;
            e = pending_rsps.pop_front();
            if (rsp_status !== e.status) begin
               $display("%0t: status expected %0d actual %0d", $realtime,
                        e.status, rsp_status);
               error_count++;
            end
            if (rsp_swept_key !== e.swept_key) begin
               $display("%0t: swept_key expected %h actual %h", $realtime,
                        e.swept_key, rsp_swept_key);
               error_count++;
            end
            if (rsp_swept_valid !== e.swept_valid) begin
               $display("%0t: swept_valid expected %0b actual %0b", $realtime,
                        e.swept_valid, rsp_swept_valid);
               error_count++;
            end
            if (rsp_last !== e.last) begin
               $display("%0t: last expected %0b actual %0b", $realtime,
                        e.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   // random response stall bursts while rsp_idle_on is set
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 3);
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IdleLimit) begin
         $display("aging_ticket_table_top test failed");
         $finish;
      end
   end

   // send one request, predict at acceptance
   task automatic send_request(logic [2:0] act, logic [31:0] owner, logic [63:0] key,
         logic [31:0] ip, logic [31:0] now, logic [31:0] life);
      // step off the edge that dropped valid, the block is busy there anyway
      @(posedge clock);
      if (req_idle_on && $urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, 3)) @(posedge clock);
      req_valid <= 1'b1;
      req_action <= act;      req_owner_id <= owner;
      req_ticket_key <= key;  req_client_ip <= ip;
      req_now_time <= now;    req_lifetime <= life;
      do @(posedge clock); while (req_stall);
      predict_ticket_op(act, owner, key, ip, now, life);
      req_valid <= 1'b0;
   endtask

   task automatic wait_all_rsps();
      while (pending_rsps.size() != 0) @(posedge clock);
   endtask

   // insert edge cases, duplicate, full table, saturation
   task automatic test_insert_limits();
      send_request(ACT_INSERT, '1, '1, '0, '1, '1);
      send_request(ACT_INSERT, '0, '1, '0, 32'd5, 32'd5);
      send_request(ACT_INSERT, '0, '0, '1, '0, '0);
      for (int i = 2; i < Depth; i++)
         send_request(ACT_INSERT, 32'h10 + i, 64'h100 + i, '0, 32'd10, i);
      send_request(ACT_INSERT, '0, 64'h55, '0, '0, '0);
      send_request(ACT_CHECK, '1, '1, '0, '0, '0);
   endtask

   // lookup failures, the ip binding, refresh, expire and undefined actions
   task automatic test_access_checks();
      send_request(ACT_CHECK, '0, 64'h1234, '0, '0, '0);
      send_request(ACT_REFRESH, '1, 64'h102, '0, 32'd20, '0);
      send_request(ACT_CHECK, '0, '0, 32'hffff_fffe, '0, '0);
      send_request(ACT_CHECK, '0, '0, '1, '0, '0);
      send_request(ACT_REFRESH, 32'h12, 64'h102, '0, 32'd20, '0);
      send_request(ACT_EXPIRE, 32'h13, 64'h103, '0, '0, '0);
      send_request(3'd5, '0, '0, '0, '0, '0);
      send_request(3'd7, '1, '1, '1, '1, '1);
   endtask

   // sweep ordering with ties, then remove every ticket whose deadline has not saturated
   task automatic test_sweep_order();
      send_request(ACT_SWEEP, '0, '0, '0, '0, '0);
      send_request(ACT_SWEEP, '0, '0, '0, 32'd16, '0);
      send_request(ACT_SWEEP, '0, '0, '0, '1, '0);
      wait_all_rsps();   // sender holds off until every expected response has arrived
   endtask

   // mostly well-formed traffic on a small pool of known keys
   task automatic test_random_traffic(int count);
      logic [2:0]  act;
      logic [63:0] key;
      logic [31:0] owner, ip;
      int p;
      for (int n = 0; n < count; n++) begin
         if (n == count - 60) begin
            req_idle_on = 1'b0;
            rsp_idle_on = 1'b0;
         end
         clock_now = clock_now + $urandom_range(0, 20);
         p = $urandom_range(0, 99);
         if (key_pool.size() == 0 || p < 25) begin
            key = {$urandom, $urandom};
            owner = $urandom;
            ip = ($urandom_range(0, 1)) ? $urandom : '0;
            if (key_pool.size() < 24) begin
               key_pool.insert(key_pool.size(), key);
               owner_pool.insert(owner_pool.size(), owner);
               ip_pool.insert(ip_pool.size(), ip);
            end
            send_request(ACT_INSERT, owner, key, ip, clock_now,
                         ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 60));
         end else if (p < 35) begin
            send_request(ACT_SWEEP, $urandom, {$urandom, $urandom}, $urandom,
                         clock_now, $urandom);
         end else begin
            int k;
            k = $urandom_range(0, key_pool.size() - 1);
            act = 3'($urandom_range(0, 3));
            owner = ($urandom_range(0, 7) == 0) ? $urandom : owner_pool[k];
            ip = ($urandom_range(0, 7) == 0) ? $urandom : ip_pool[k];
            key = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : key_pool[k];
            if ($urandom_range(0, 19) == 0) act = 3'($urandom_range(5, 7));
            send_request(act, owner, key, ip, clock_now, $urandom);
         end
      end
   endtask

   initial begin
      stamp_ctr = '0;
      foreach (tbl_used[i]) tbl_used[i] = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_insert_limits();
      test_access_checks();
      test_sweep_order();
      test_random_traffic(280);
      wait_all_rsps();
      repeat (3 * Depth + 20) @(posedge clock);
      if (error_count == 0 && pending_rsps.size() == 0)
         $display("aging_ticket_table_top test passed");
      else
         $display("aging_ticket_table_top test failed");
      $finish;
   end
endmodule
